[src/zero_stuff_interpolating_fir_assert.svh]
// Assertion macros used by the interpolating FIR datapath.
`ifndef ZERO_STUFF_INTERPOLATING_FIR_ASSERT_SVH
`define ZERO_STUFF_INTERPOLATING_FIR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define ZSIF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("zsif: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define ZSIF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("zsif: next-cycle check failed");

`endif

[src/zsif_pkg.sv]
// Shared types and constants of the zero-stuffing interpolating FIR.
package zsif_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int TAP_CNT_W  = 7;
  localparam int COEF_IDX_W = 6;
  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 2;
  localparam int FRAC_BITS  = 15;
  localparam int ROUND_HALF = 16384;
  localparam int OUT_MAX    = 32767;
  localparam int OUT_MIN    = -32768;

  localparam logic REQ_DATA = 1'b0;
  localparam logic REQ_COEF = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_coef;
    logic start_sample;
    logic pos_step;
    logic next_r;
    logic issue;
    logic scale;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pos_skip;
    logic tap_ok;
    logic pipe_busy;
    logic r_last;
    logic out_free;
  } status_t;

endpackage

[src/zsif_ctrl.sv]
// Controller state machine of the interpolating FIR.
module zsif_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             req_type,
  output logic             in_ready,
  input  zsif_pkg::status_t sts,
  output zsif_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_POS   = 3'd1;
  localparam logic [2:0] S_MAC   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_SCALE = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (req_type == zsif_pkg::REQ_COEF) begin
            cmd.load_coef = 1'b1;
          end else begin
            cmd.start_sample = 1'b1;
            state_next       = S_POS;
          end
        end
      end
      S_POS: begin
        cmd.pos_step = 1'b1;
        if (sts.pos_skip) begin
          if (sts.r_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.next_r = 1'b1;
          end
        end else begin
          state_next = S_MAC;
        end
      end
      S_MAC: begin
        if (sts.tap_ok) begin
          cmd.issue = 1'b1;
        end else begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_next = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.r_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.next_r = 1'b1;
            state_next = S_POS;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[src/zsif_datapath.sv]
// Datapath: coefficient memory, sample history, MAC pipeline and output register.
`include "zero_stuff_interpolating_fir_assert.svh"
module zsif_datapath #(
  parameter int UPSAMPLE_FACTOR = 8,
  parameter int MAX_TAPS        = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  zsif_pkg::cmd_t                        cmd,
  output zsif_pkg::status_t                     sts,
  input  logic                                  frame_start,
  input  logic signed [zsif_pkg::SAMPLE_W-1:0]  sample_in,
  input  logic [zsif_pkg::COEF_IDX_W-1:0]       coef_index,
  input  logic signed [zsif_pkg::COEF_W-1:0]    coef_value,
  input  logic                                  cfg_wr,
  input  logic [zsif_pkg::TAP_CNT_W-1:0]        cfg_data,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic signed [zsif_pkg::SAMPLE_W-1:0]  sample_out,
  output logic                                  last_of_run,
  output logic                                  clipped
);

  localparam int HIST_DEPTH = (MAX_TAPS - 1) / UPSAMPLE_FACTOR + 1;
  localparam int AW    = $clog2(MAX_TAPS);
  localparam int WW    = $clog2(MAX_TAPS + 1);
  localparam int KW    = $clog2(MAX_TAPS + UPSAMPLE_FACTOR);
  localparam int RW    = $clog2(UPSAMPLE_FACTOR);
  localparam int JW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int PW    = zsif_pkg::SAMPLE_W + zsif_pkg::COEF_W;
  localparam int ACC_W = PW + $clog2(HIST_DEPTH + 1);
  localparam int SW    = ACC_W + 5;
  localparam int RESET_TAPS = (MAX_TAPS < 64) ? MAX_TAPS : 64;

  // Coefficient memory with per-entry valid bits standing in for the zero reset.
  logic signed [zsif_pkg::COEF_W-1:0] coef_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]                coef_vld;
  logic signed [zsif_pkg::COEF_W-1:0] coef_q;
  logic                               cvld_q;
  logic                               coef_in_range;

  logic signed [zsif_pkg::SAMPLE_W-1:0] hist [HIST_DEPTH];
  logic [WW-1:0]  warmup;
  logic [WW-1:0]  taps;
  logic [8:0]     cfg_wide;
  logic [RW-1:0]  r;
  logic [KW-1:0]  k;
  logic [JW-1:0]  j;

  logic signed [zsif_pkg::SAMPLE_W-1:0] samp_q;
  logic signed [zsif_pkg::COEF_W-1:0]   coef_eff;
  logic signed [PW-1:0]                 prod;
  logic                                 s1_v;
  logic                                 s2_v;
  logic signed [ACC_W-1:0]              acc;
  logic signed [SW-1:0]                 scaled;
  logic signed [SW-1:0]                 q_full;
  logic                                 q_hi;
  logic                                 q_lo;

  assign coef_in_range = ({3'b000, coef_index} < 9'(MAX_TAPS));
  assign cfg_wide      = {2'b00, cfg_data};

  always_ff @(posedge clk) begin
    if (cmd.load_coef && coef_in_range) begin
      coef_mem[AW'(coef_index)] <= coef_value;
    end
    if (cmd.issue) begin
      coef_q <= coef_mem[k[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_vld <= '0;
      cvld_q   <= 1'b0;
    end else begin
      if (cmd.load_coef && coef_in_range) begin
        coef_vld[AW'(coef_index)] <= 1'b1;
      end
      if (cmd.issue) begin
        cvld_q <= coef_vld[k[AW-1:0]];
      end
    end
  end

  // Tap count register, stored already clamped to 1..MAX_TAPS.
  always_ff @(posedge clk) begin
    if (rst) begin
      taps <= WW'(RESET_TAPS);
    end else if (cfg_wr) begin
      if (cfg_data == '0) begin
        taps <= WW'(1);
      end else if (cfg_wide > 9'(MAX_TAPS)) begin
        taps <= WW'(MAX_TAPS);
      end else begin
        taps <= WW'(cfg_data);
      end
    end
  end

  // History shift line and frame warm-up counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist[i] <= '0;
      end
      warmup <= '0;
    end else begin
      if (cmd.start_sample) begin
        hist[0] <= sample_in;
        for (int i = 1; i < HIST_DEPTH; i++) begin
          hist[i] <= frame_start ? '0 : hist[i-1];
        end
        if (frame_start) begin
          warmup <= '0;
        end
      end else if (cmd.pos_step && (warmup < WW'(MAX_TAPS))) begin
        warmup <= warmup + WW'(1);
      end
    end
  end

  // Phase and tap counters.
  always_ff @(posedge clk) begin
    if (cmd.start_sample) begin
      r <= '0;
    end else if (cmd.next_r) begin
      r <= r + RW'(1);
    end
    if (cmd.pos_step) begin
      k <= KW'(r);
      j <= '0;
    end else if (cmd.issue) begin
      k <= k + KW'(UPSAMPLE_FACTOR);
      j <= j + JW'(1);
    end
  end

  // Multiply-accumulate pipeline: read, multiply, accumulate.
  assign coef_eff = cvld_q ? coef_q : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= cmd.issue;
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      samp_q <= hist[j];
    end
    prod <= samp_q * coef_eff;
    if (cmd.pos_step) begin
      acc <= '0;
    end else if (s2_v) begin
      acc <= acc + ACC_W'(prod);
    end
    if (cmd.scale) begin
      scaled <= SW'(acc) * SW'(UPSAMPLE_FACTOR) + SW'(zsif_pkg::ROUND_HALF);
    end
  end

  // Floor shift and saturation.
  assign q_full = scaled >>> zsif_pkg::FRAC_BITS;
  assign q_hi   = (q_full > SW'(zsif_pkg::OUT_MAX));
  assign q_lo   = (q_full < SW'(zsif_pkg::OUT_MIN));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (q_hi) begin
        sample_out <= zsif_pkg::SAMPLE_W'(zsif_pkg::OUT_MAX);
      end else if (q_lo) begin
        sample_out <= zsif_pkg::SAMPLE_W'(zsif_pkg::OUT_MIN);
      end else begin
        sample_out <= q_full[zsif_pkg::SAMPLE_W-1:0];
      end
      clipped     <= q_hi | q_lo;
      last_of_run <= sts.r_last;
    end
  end

  assign sts.pos_skip  = (({1'b0, warmup} + (WW+1)'(1)) < {1'b0, taps});
  assign sts.tap_ok    = (k < KW'(taps));
  assign sts.pipe_busy = s1_v | s2_v;
  assign sts.r_last    = (r == RW'(UPSAMPLE_FACTOR - 1));
  assign sts.out_free  = !out_valid || out_ready;

  `ZSIF_ASSERT_NOW(a_emit_free, clk, rst, cmd.emit, (!out_valid || out_ready))
  `ZSIF_ASSERT_NOW(a_issue_in_range, clk, rst, cmd.issue, (k < KW'(taps)))
  `ZSIF_ASSERT_NOW(a_scale_drained, clk, rst, cmd.scale, (!s1_v && !s2_v))
  `ZSIF_ASSERT_NEXT(a_emit_shows, clk, rst, cmd.emit, out_valid)

endmodule

[src/zero_stuff_interpolating_fir.sv]
// Top level of the zero-stuffing interpolating FIR filter.
// Usage: input transactions arrive on the s_axis channel. tuser bit 0 selects the kind:
// 0 is a data sample, 1 is a coefficient load that writes one Q1.15 tap and gives
// no output. tuser bit 1 marks a frame start, which clears the sample history and
// the warm-up count before the sample. Each data sample produces up to
// UPSAMPLE_FACTOR output transactions on m_axis, with tlast on the last one and
// tuser set when the output was saturated. Positions in the warm-up part of a
// frame (index below tap_count-1) produce nothing.
// Sequence: a coefficient load is taken in idle and the block stays ready. A data
// sample is accepted, each suppressed position is skipped, and each produced position
// r walks the taps of phase r, drains the pipeline, scales and emits its result,
// with the single multiply-accumulate unit walking the taps one per cycle.
// The cfg channel writes tap_count; it is always ready and must be written idle.
// Reset (rst, synchronous) sets tap_count to MAX_TAPS capped at 64, zeros all coefficients, the history
// and the warm-up count. A stalled receiver holds the output register; the block
// waits with the next result, and takes new input once the current sample is done.
module zero_stuff_interpolating_fir #(
  parameter int UPSAMPLE_FACTOR = 8,
  parameter int MAX_TAPS        = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // sample_in[15:0], coef_index[21:16], coef_value[37:22], zero fill [39:38]
  input  logic [zsif_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // req_type[0], frame_start[1]
  input  logic [zsif_pkg::IN_USER_W-1:0]     s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // sample_out[15:0]
  output logic [zsif_pkg::SAMPLE_W-1:0]      m_axis_tdata,
  output logic                               m_axis_tlast,
  // clipped[0]
  output logic [0:0]                         m_axis_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [zsif_pkg::TAP_CNT_W-1:0]     cfg_data
);

  zsif_pkg::cmd_t    cmd;
  zsif_pkg::status_t sts;
  logic signed [zsif_pkg::SAMPLE_W-1:0] sample_out;
  logic                                 clipped;

  // Configuration writes land directly in the tap count register, so the channel never stalls.
  assign cfg_ready = 1'b1;

  zsif_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .req_type (s_axis_tuser[0]),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  zsif_datapath #(
    .UPSAMPLE_FACTOR (UPSAMPLE_FACTOR),
    .MAX_TAPS        (MAX_TAPS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .frame_start (s_axis_tuser[1]),
    .sample_in   (s_axis_tdata[15:0]),
    .coef_index  (s_axis_tdata[21:16]),
    .coef_value  (s_axis_tdata[37:22]),
    .cfg_wr      (cfg_valid & cfg_ready),
    .cfg_data    (cfg_data),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .sample_out  (sample_out),
    .last_of_run (m_axis_tlast),
    .clipped     (clipped)
  );

  assign m_axis_tdata    = sample_out;
  assign m_axis_tuser[0] = clipped;

endmodule
